FILE: hw/rtl/rtka_pkg.sv
`timescale 1ns / 1ps

package rtka_pkg;

  localparam int KEYS_DEF = 64;

  localparam int KEY_W   = 6;
  localparam int DIST_W  = 14;
  localparam int TIME_W  = 32;
  localparam int GAP_W   = 10;
  localparam int TICK_W  = 8;
  localparam int STILL_W = 5;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 14;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  localparam logic [DIST_W-1:0]  FULL_TRAVEL  = DIST_W'(10000);
  localparam logic [STILL_W-1:0] RELOCK_COUNT = STILL_W'(30);

  typedef enum logic [CFG_A_W-1:0] {
    CFG_ACT_POINT   = 3'd0,
    CFG_RT_PRESS    = 3'd1,
    CFG_RT_RELEASE  = 3'd2,
    CFG_DZ_TOP      = 3'd3,
    CFG_DZ_BOTTOM   = 3'd4,
    CFG_CONTINUOUS  = 3'd5,
    CFG_HYST_GAP    = 3'd6,
    CFG_DEBOUNCE    = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIR_INACTIVE = 2'd0,
    DIR_DOWN     = 2'd1,
    DIR_UP       = 2'd2
  } dir_t;

  // Per-key state held in the state memory
  typedef struct packed {
    logic                moving;
    logic [DIST_W-1:0]   locked;
    logic [DIST_W-1:0]   anchor;
    logic [STILL_W-1:0]  still;
    logic [DIST_W-1:0]   extremum;
    dir_t                dir;
    logic                pressed;
    logic [TIME_W-1:0]   last_change;
  } key_ctx_t;

  typedef struct packed {
    logic                state_changed;
    dir_t                direction;
    logic                pressed;
    logic [DIST_W-1:0]   stable_distance;
    logic [KEY_W-1:0]    out_key;
  } result_t;

  function automatic logic [DIST_W-1:0] abs_diff(input logic [DIST_W-1:0] a,
                                                 input logic [DIST_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: hw/rtl/rapid_trigger_key_actuation_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata fields (lowest bit first)
// in_*      slave      key_index[5:0], travel_distance[19:6], time_ms[51:20], zero pad to 56
// out_*     master     out_key[5:0], stable_distance[19:6], pressed[20], direction[22:21],
//                      state_changed[23]
// cfg_*     write      cfg_addr selects register, cfg_wdata carries value, no read-back
//
// One transaction per cycle sustained while the output is not stalled; out_tvalid is
// registered, and an input transaction passes the middle stage and the output register
// before its result is offered. The per-key state memory is read on accept and written
// as the item leaves the middle stage, with a bypass so a key can follow itself in the next cycle.
// Synchronous active-low reset clears per-key valid bits; an entry not yet written reads
// as zero, so no clearing pass is needed. Config registers reset to their defaults.
// A stalled output holds the middle stage; input is still taken while the middle stage
// is free.

module rapid_trigger_key_actuation_unit
  import rtka_pkg::*;
#(
  parameter int KEYS = KEYS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // key_index, travel_distance, time_ms, zero pad
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // out_key, stable_distance, pressed, direction, state_changed
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic                    cfg_wr_en,
  input  logic [CFG_A_W-1:0]      cfg_addr,
  input  logic [CFG_D_W-1:0]      cfg_wdata
);

  localparam int IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam logic [8:0] KEYS_LIM = 9'(KEYS);

  // configuration
  logic [DIST_W-1:0] ap_r, press_r, release_r, dz_top_r, dz_bot_r;
  logic              cont_r;
  logic [GAP_W-1:0]  gap_r;
  logic [TICK_W-1:0] ticks_r;

  // input decode
  logic [KEY_W-1:0]  in_key;
  logic [DIST_W-1:0] in_raw;
  logic [TIME_W-1:0] in_time;
  logic              in_fire;
  logic              in_range;
  logic [IDX_W-1:0]  in_idx;

  // middle stage
  logic              s1_valid_r;
  logic [KEY_W-1:0]  s1_key_r;
  logic [DIST_W-1:0] s1_raw_r;
  logic [TIME_W-1:0] s1_time_r;
  logic              s1_range_r;
  logic              s1_adv;
  logic              s1_wr;
  logic [IDX_W-1:0]  s1_idx;

  key_ctx_t          state_mem [KEYS];
  logic [KEYS-1:0]   vld_r;
  key_ctx_t          rd_r;
  logic              rd_vld_r;
  key_ctx_t          fwd_r;
  logic              fwd_sel_r;
  logic              fwd_sel_nxt;

  key_ctx_t          cur;
  key_ctx_t          st_nxt;
  result_t           res;

  // output register
  logic              out_valid_r;
  result_t           out_r;

  // datapath temporaries
  logic [DIST_W-1:0] raw;
  logic [DIST_W-1:0] lock_dist;
  logic [DIST_W-1:0] thr;
  logic [DIST_W-1:0] deact;
  logic [DIST_W:0]   arm_sum;
  logic [DIST_W-1:0] arm;
  logic [DIST_W-1:0] bot;
  logic [DIST_W-1:0] up;
  logic [DIST_W-1:0] reset_pt;
  logic [STILL_W-1:0] still_inc;
  logic              want;
  logic              changed;
  logic [TIME_W-1:0] elapsed;

  assign in_key   = in_tdata[5:0];
  assign in_raw   = in_tdata[19:6];
  assign in_time  = in_tdata[51:20];
  assign in_range = {3'b000, in_key} < KEYS_LIM;
  assign in_idx   = IDX_W'(in_key);
  assign s1_idx   = IDX_W'(s1_key_r);

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = rst_n && (!s1_valid_r || s1_adv);
  assign in_fire   = in_tvalid && in_tready;
  assign s1_wr     = s1_valid_r && s1_adv && s1_range_r;

  assign fwd_sel_nxt = s1_wr && in_range && (s1_key_r == in_key);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_r      <= DIST_W'(2000);
      press_r   <= '0;
      release_r <= '0;
      dz_top_r  <= '0;
      dz_bot_r  <= '0;
      cont_r    <= 1'b0;
      gap_r     <= GAP_W'(138);
      ticks_r   <= TICK_W'(5);
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_ACT_POINT:  ap_r      <= cfg_wdata;
        CFG_RT_PRESS:   press_r   <= cfg_wdata;
        CFG_RT_RELEASE: release_r <= cfg_wdata;
        CFG_DZ_TOP:     dz_top_r  <= cfg_wdata;
        CFG_DZ_BOTTOM:  dz_bot_r  <= cfg_wdata;
        CFG_CONTINUOUS: cont_r    <= cfg_wdata[0];
        CFG_HYST_GAP:   gap_r     <= cfg_wdata[GAP_W-1:0];
        CFG_DEBOUNCE:   ticks_r   <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_sel_r   <= 1'b0;
      vld_r       <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (in_fire) begin
        fwd_sel_r <= fwd_sel_nxt;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_wr) begin
        vld_r[s1_idx] <= 1'b1;
      end
    end
  end

  // Payload and state memory
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_key_r   <= in_key;
      s1_raw_r   <= in_raw;
      s1_time_r  <= in_time;
      s1_range_r <= in_range;
      fwd_r      <= st_nxt;
      rd_vld_r   <= in_range ? vld_r[in_idx] : 1'b0;
      if (in_range) begin
        rd_r <= state_mem[in_idx];
      end
    end
    if (s1_wr) begin
      state_mem[s1_idx] <= st_nxt;
    end
    if (s1_adv && s1_valid_r) begin
      out_r <= res;
    end
  end

  // Per-key update: noise lock, actuation, debounce
  always_comb begin
    if (fwd_sel_r) begin
      cur = fwd_r;
    end else if (rd_vld_r) begin
      cur = rd_r;
    end else begin
      cur = '0;
    end
    st_nxt    = cur;
    raw       = (s1_raw_r > FULL_TRAVEL) ? FULL_TRAVEL : s1_raw_r;
    thr       = DIST_W'(gap_r[GAP_W-1:3]);
    still_inc = cur.still + STILL_W'(1);
    lock_dist = raw;

    // noise lock
    if (raw == '0 || raw == FULL_TRAVEL) begin
      st_nxt.moving = 1'b0;
      st_nxt.locked = raw;
      st_nxt.anchor = raw;
      st_nxt.still  = '0;
    end else if (!cur.moving) begin
      if (abs_diff(raw, cur.locked) > thr) begin
        st_nxt.moving = 1'b1;
        st_nxt.anchor = raw;
        st_nxt.still  = '0;
      end else begin
        lock_dist = cur.locked;
      end
    end else if (abs_diff(raw, cur.anchor) <= thr) begin
      st_nxt.still = still_inc;
      if (still_inc >= RELOCK_COUNT) begin
        st_nxt.moving = 1'b0;
        st_nxt.locked = raw;
      end
    end else begin
      st_nxt.anchor = raw;
      st_nxt.still  = '0;
    end

    deact    = (ap_r > DIST_W'(gap_r)) ? (ap_r - DIST_W'(gap_r)) : '0;
    arm_sum  = {1'b0, ap_r} + (DIST_W+1)'(gap_r);
    arm      = (arm_sum < {1'b0, FULL_TRAVEL}) ? arm_sum[DIST_W-1:0] : FULL_TRAVEL;
    bot      = (dz_bot_r < FULL_TRAVEL) ? (FULL_TRAVEL - dz_bot_r) : FULL_TRAVEL;
    up       = (release_r == '0) ? press_r : release_r;
    reset_pt = (cont_r && (dz_top_r < deact)) ? dz_top_r : deact;
    want     = cur.pressed;

    if (press_r == '0) begin
      // plain hysteresis actuation
      st_nxt.dir = DIR_INACTIVE;
      if (cur.pressed) begin
        if (lock_dist <= deact) want = 1'b0;
      end else if (lock_dist >= ap_r) begin
        want = 1'b1;
      end
    end else if (lock_dist <= dz_top_r) begin
      st_nxt.extremum = lock_dist;
      if (!cur.pressed || lock_dist <= deact) begin
        st_nxt.dir = DIR_INACTIVE;
        want       = 1'b0;
      end
    end else if (lock_dist >= bot) begin
      st_nxt.extremum = lock_dist;
      st_nxt.dir      = DIR_DOWN;
      want            = 1'b1;
    end else begin
      case (cur.dir)
        DIR_INACTIVE: begin
          if (lock_dist >= ap_r) begin
            st_nxt.extremum = lock_dist;
            st_nxt.dir      = DIR_DOWN;
            want            = 1'b1;
          end
        end
        DIR_DOWN: begin
          if (lock_dist <= deact) begin
            st_nxt.extremum = lock_dist;
            st_nxt.dir      = DIR_INACTIVE;
            want            = 1'b0;
          end else if (cur.extremum >= arm &&
                       ({1'b0, lock_dist} + {1'b0, up}) < {1'b0, cur.extremum}) begin
            st_nxt.extremum = lock_dist;
            st_nxt.dir      = DIR_UP;
            want            = 1'b0;
          end else if (lock_dist > cur.extremum) begin
            st_nxt.extremum = lock_dist;
          end
        end
        DIR_UP: begin
          if (lock_dist <= reset_pt) begin
            st_nxt.extremum = lock_dist;
            st_nxt.dir      = DIR_INACTIVE;
            want            = 1'b0;
          end else if (({1'b0, cur.extremum} + {1'b0, press_r}) < {1'b0, lock_dist} &&
                       (cont_r || lock_dist >= ap_r)) begin
            st_nxt.extremum = lock_dist;
            st_nxt.dir      = DIR_DOWN;
            want            = 1'b1;
          end else if (lock_dist < cur.extremum) begin
            st_nxt.extremum = lock_dist;
          end
        end
        default: ;
      endcase
    end

    // lockout debounce, wrapping time difference
    elapsed = s1_time_r - cur.last_change;
    changed = 1'b0;
    if (want != cur.pressed && elapsed >= TIME_W'(ticks_r)) begin
      st_nxt.pressed     = want;
      st_nxt.last_change = s1_time_r;
      changed            = 1'b1;
    end

    res.out_key = s1_key_r;
    if (s1_range_r) begin
      res.stable_distance = lock_dist;
      res.pressed         = st_nxt.pressed;
      res.direction       = st_nxt.dir;
      res.state_changed   = changed;
    end else begin
      res.stable_distance = '0;
      res.pressed         = 1'b0;
      res.direction       = DIR_INACTIVE;
      res.state_changed   = 1'b0;
    end
  end

  // A full pipeline is the only reason to refuse input
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r))
    else $error("input refused with a free stage");

  // A stalled middle stage keeps its key and its bypass selection
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_key_r) && $stable(fwd_sel_r)))
    else $error("middle stage lost its transaction under stall");

  // A reported change always flips the stored pressed state
  a_change_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && res.state_changed) |-> (st_nxt.pressed != cur.pressed))
    else $error("change flagged without a pressed flip");

  // Bypass only ever selected for a key that was written the cycle before
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && fwd_sel_nxt) |=> (fwd_sel_r && s1_range_r && s1_key_r == $past(s1_key_r)))
    else $error("bypass selected for a different key");

  // Results never exceed full travel
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.stable_distance <= FULL_TRAVEL))
    else $error("stable distance above full travel");

endmodule
